@@ sv/rcmt_pkg.sv @@
// ----------------------------------------------------------------------------
// rcmt_pkg
// Shared types and constants for the RC mode transition controller.
// ----------------------------------------------------------------------------
package rcmt_pkg;

  localparam int unsigned WW = 15;
  localparam int unsigned NCH = 4;
  localparam int unsigned NOUTS = 9;
  localparam int unsigned IW = 4;

  localparam logic [2:0] CFG_PWM_MIN = 3'd0;
  localparam logic [2:0] CFG_PWM_MAX = 3'd1;
  localparam logic [2:0] CFG_LOW_THR = 3'd2;
  localparam logic [2:0] CFG_HIGH_THR = 3'd3;
  localparam logic [2:0] CFG_FLOOR = 3'd4;

  localparam logic [1:0] ACT_STOP = 2'd0;
  localparam logic [1:0] ACT_EXTEND = 2'd1;
  localparam logic [1:0] ACT_RETRACT = 2'd2;

  typedef struct packed {
    logic [WW-1:0] pwm_min;
    logic [WW-1:0] pwm_max;
    logic [WW-1:0] low_thr;
    logic [WW-1:0] high_thr;
    logic [WW-1:0] floor_w;
  } cfg_t;

  typedef struct packed {
    logic [WW-1:0] lock_pulse;
    logic [WW-1:0] mode_pulse;
    logic [WW-1:0] actuator_pulse;
    logic [WW-1:0] gear_pulse;
  } in_item_t;

  typedef struct packed {
    logic          is_status;
    logic [IW-1:0] output_index;
    logic [WW-1:0] output_value;
    logic          locked;
    logic          surface_mode;
    logic          transition_active;
    logic [1:0]    actuator_state;
    logic          gear_down;
    logic          last;
  } out_item_t;

  // per-channel threshold findings
  typedef struct packed {
    logic hi;
    logic lo;
    logic above_floor;
  } lane_flags_t;

  // one frame's change set handed to the emitter
  typedef struct packed {
    logic [NOUTS-1:0] chg;
    logic [5:0][7:0]  ang;
    logic [2:0][WW-1:0] wid;
    logic          locked;
    logic          surface;
    logic          active;
    logic [1:0]    act;
    logic          gear;
  } frame_t;

endpackage

@@ sv/rcmt_if.sv @@
// ----------------------------------------------------------------------------
// rcmt_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface rcmt_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/rcmt_lane.sv @@
// ----------------------------------------------------------------------------
// rcmt_lane
// One channel: floor test, clamp, moving-average window and thresholds.
// ----------------------------------------------------------------------------
module rcmt_lane #(
  parameter int unsigned TAPS = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [$clog2(TAPS+1)-1:0] pos_i,
  input  logic [rcmt_pkg::WW-1:0] raw_i,
  input  rcmt_pkg::cfg_t        cfg_i,
  output rcmt_pkg::lane_flags_t flags_o
);
  import rcmt_pkg::*;

  localparam int unsigned SW = WW + $clog2(TAPS+1);
  localparam int unsigned PW = $clog2(TAPS+1);
  // reciprocal of TAPS, exact for every window sum
  localparam int unsigned RS = SW + 4;
  localparam int unsigned MW = RS + 1;
  localparam int unsigned PRW = SW + RS + 1;
  localparam logic [MW-1:0] RM = MW'((2**RS + TAPS - 1) / TAPS);

  logic [TAPS-1:0][WW-1:0] win_q;
  logic [WW-1:0] samp;
  logic [SW-1:0] sum;
  logic [PRW-1:0] prod;
  logic [WW-1:0] avg;

  always_comb begin
    samp = raw_i;
    if (raw_i > cfg_i.floor_w) begin
      if (raw_i < cfg_i.pwm_min) samp = cfg_i.pwm_min;
      else if (raw_i > cfg_i.pwm_max) samp = cfg_i.pwm_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (en_i) begin
      for (int k = 0; k < TAPS; k++) begin
        if (pos_i == PW'(k)) win_q[k] <= samp;
      end
    end
  end

  always_comb begin
    sum = SW'(samp);
    for (int k = 0; k < TAPS; k++) begin
      if (pos_i != PW'(k)) sum = sum + SW'(win_q[k]);
    end
    prod = PRW'(sum) * PRW'(RM);
    avg = WW'(prod >> RS);
    flags_o.hi = avg > cfg_i.high_thr;
    flags_o.lo = avg < cfg_i.low_thr;
    flags_o.above_floor = avg > cfg_i.floor_w;
  end

endmodule

@@ sv/rcmt_merge.sv @@
// ----------------------------------------------------------------------------
// rcmt_merge
// Combines lane findings into mode state, ramp angles and output widths.
// ----------------------------------------------------------------------------
module rcmt_merge #(
  parameter int unsigned STEPS1 = 100,
  parameter int unsigned STEPS2 = 90
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  rcmt_pkg::lane_flags_t [3:0]    flags_i,
  input  rcmt_pkg::cfg_t                 cfg_i,
  output rcmt_pkg::frame_t               frame_o
);
  import rcmt_pkg::*;

  // reciprocals of the step counts, exact for 14-bit products
  localparam int unsigned RS = 21;
  localparam logic [21:0] M1 = 22'((2**RS + STEPS1 - 1) / STEPS1);
  localparam logic [21:0] M2 = 22'((2**RS + STEPS2 - 1) / STEPS2);

  logic lock_q, lock_d, mode_q, mode_d, act_q, act_d, gear_q, gear_d;
  logic [1:0] am_d;
  logic [6:0] s1_q, s1_d, s2_q, s2_d;
  logic [5:0][7:0] ang_q, ang_d;
  logic [2:0][WW-1:0] wid_q, wid_d;
  logic [NOUTS-1:0] chg;
  logic [13:0] p1, p2;
  logic [35:0] q1, q2;
  logic [7:0] d1, d2;
  logic [5:0][7:0] na;
  logic [5:0] upd;
  logic [WW:0] mid;
  logic [WW-1:0] w, g;

  function automatic logic [WW-1:0] clampv(logic [WW-1:0] v, cfg_t c);
    if (v < c.pwm_min) return c.pwm_min;
    if (v > c.pwm_max) return c.pwm_max;
    return v;
  endfunction

  function automatic logic [7:0] cap(logic [7:0] v);
    return (v > 8'd180) ? 8'd180 : v;
  endfunction

  always_comb begin
    lock_d = lock_q;
    if (flags_i[0].lo) lock_d = 1'b1;
    else if (flags_i[0].hi) lock_d = 1'b0;
    mode_d = mode_q;
    act_d = act_q;
    if (!lock_d && !act_q) begin
      if (flags_i[1].lo && mode_q) begin
        mode_d = 1'b0; act_d = 1'b1;
      end else if (flags_i[1].hi && !mode_q) begin
        mode_d = 1'b1; act_d = 1'b1;
      end
    end
    if (flags_i[2].hi) am_d = ACT_EXTEND;
    else if (flags_i[2].lo && flags_i[2].above_floor) am_d = ACT_RETRACT;
    else am_d = ACT_STOP;
    gear_d = gear_q;
    if (flags_i[3].hi) gear_d = 1'b1;
    else if (flags_i[3].lo && flags_i[3].above_floor) gear_d = 1'b0;

    p1 = 14'(s1_q) * 14'd110;
    p2 = 14'(s2_q) * 14'd90;
    q1 = 36'(p1) * 36'(M1);
    q2 = 36'(p2) * 36'(M2);
    d1 = 8'(q1 >> RS);
    d2 = 8'(q2 >> RS);
    s1_d = s1_q;
    s2_d = s2_q;
    upd = '0;
    na = ang_q;
    if (act_d) begin
      if (32'(s1_q) < STEPS1) begin
        upd[1:0] = 2'b11;
        na[0] = cap(mode_d ? 8'd130 - d1 : 8'd20 + d1);
        na[1] = cap(mode_d ? 8'd45 + d1 : 8'd155 - d1);
        s1_d = s1_q + 7'd1;
      end else if (32'(s2_q) < STEPS2) begin
        upd[5:2] = 4'b1111;
        na[2] = cap(mode_d ? 8'd90 - d2 : d2);
        na[3] = na[2];
        na[4] = cap(mode_d ? 8'd80 + d2 : 8'd170 - d2);
        na[5] = na[4];
        s2_d = s2_q + 7'd1;
      end else begin
        act_d = 1'b0;
        s1_d = '0;
        s2_d = '0;
      end
    end
    for (int i = 0; i < 6; i++) begin
      chg[i] = upd[i] && (na[i] != ang_q[i]);
      ang_d[i] = chg[i] ? na[i] : ang_q[i];
    end
    mid = ({1'b0, cfg_i.pwm_min} + {1'b0, cfg_i.pwm_max}) >> 1;
    case (am_d)
      ACT_EXTEND: w = cfg_i.pwm_max;
      ACT_RETRACT: w = cfg_i.pwm_min;
      default: w = WW'(mid);
    endcase
    w = clampv(w, cfg_i);
    g = clampv(gear_d ? cfg_i.pwm_max : cfg_i.pwm_min, cfg_i);
    wid_d[0] = w;
    wid_d[1] = w;
    wid_d[2] = g;
    for (int i = 0; i < 3; i++) chg[6+i] = wid_d[i] != wid_q[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= 1'b1;
      mode_q <= 1'b0;
      act_q <= 1'b0;
      gear_q <= 1'b0;
      s1_q <= '0;
      s2_q <= '0;
      ang_q <= {8'd80, 8'd80, 8'd90, 8'd90, 8'd45, 8'd130};
      wid_q <= {WW'(1000), WW'(1500), WW'(1500)};
      frame_o <= '0;
    end else if (en_i) begin
      lock_q <= lock_d;
      mode_q <= mode_d;
      act_q <= act_d;
      gear_q <= gear_d;
      s1_q <= s1_d;
      s2_q <= s2_d;
      ang_q <= ang_d;
      wid_q <= wid_d;
      frame_o.chg <= chg;
      frame_o.ang <= ang_d;
      frame_o.wid <= wid_d;
      frame_o.locked <= lock_d;
      frame_o.surface <= mode_d;
      frame_o.active <= act_d;
      frame_o.act <= am_d;
      frame_o.gear <= gear_d;
    end
  end

endmodule

@@ sv/rcmt_emit.sv @@
// ----------------------------------------------------------------------------
// rcmt_emit
// Serializes a frame's change set into result transfers, status last.
// ----------------------------------------------------------------------------
module rcmt_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  rcmt_pkg::frame_t frame_i,
  output logic             busy_o,
  output logic             done_o,
  rcmt_if.source           out
);
  import rcmt_pkg::*;

  logic busy_q;
  frame_t fr_q;
  logic [NOUTS-1:0] pend_q;
  logic [IW-1:0] idx;
  logic fire;

  always_comb begin
    idx = '0;
    for (int i = NOUTS - 1; i >= 0; i--) begin
      if (pend_q[i]) idx = IW'(i);
    end
    out.valid = busy_q;
    out.data = '0;
    if (pend_q != '0) begin
      out.data.output_index = idx;
      out.data.output_value = (idx < IW'(6)) ? WW'(fr_q.ang[idx[2:0]])
                                             : fr_q.wid[idx[1:0] - 2'd2];
    end else begin
      out.data.is_status = 1'b1;
      out.data.locked = fr_q.locked;
      out.data.surface_mode = fr_q.surface;
      out.data.transition_active = fr_q.active;
      out.data.actuator_state = fr_q.act;
      out.data.gear_down = fr_q.gear;
      out.data.last = 1'b1;
    end
    fire = busy_q && out.ready;
    done_o = fire && (pend_q == '0);
    busy_o = busy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      pend_q <= frame_i.chg;
    end else if (fire) begin
      if (pend_q == '0) busy_q <= 1'b0;
      else pend_q[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) fr_q <= frame_i;
  end

endmodule

@@ sv/rc_mode_transition_controller.sv @@
// ----------------------------------------------------------------------------
// rc_mode_transition_controller
// Four-lane RC frame filter with servo ramp and change reporting.
// ----------------------------------------------------------------------------
// One frame enters per transfer; four lanes clamp and filter the channels in
// the accepting cycle and a merge stage registers the new state at that edge.
// The frame waits in stage_q until the emitter is idle or finishing, and the
// emitter then sends one result per cycle while the sink is ready: the changed
// outputs in index order, then a status item. The first result is offered the
// cycle after the emitter takes the frame. The next frame is taken while the
// previous results are still being sent.
module rc_mode_transition_controller #(
  parameter int unsigned FILTER_TAPS = 5,
  parameter int unsigned FIRST_PHASE_STEPS = 100,
  parameter int unsigned SECOND_PHASE_STEPS = 90
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [rcmt_pkg::WW-1:0] cfg_data_i,
  rcmt_if.sink                   in,
  rcmt_if.source                 out
);
  import rcmt_pkg::*;

  localparam int unsigned PW = $clog2(FILTER_TAPS+1);

  cfg_t cfg_q;
  logic [PW-1:0] pos_q;
  lane_flags_t [3:0] flags;
  logic [3:0][WW-1:0] raw;
  logic acc, stage_q, busy, done;
  frame_t frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= {WW'(1000), WW'(2000), WW'(1100), WW'(1900), WW'(500)};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PWM_MIN: cfg_q.pwm_min <= cfg_data_i;
        CFG_PWM_MAX: cfg_q.pwm_max <= cfg_data_i;
        CFG_LOW_THR: cfg_q.low_thr <= cfg_data_i;
        CFG_HIGH_THR: cfg_q.high_thr <= cfg_data_i;
        CFG_FLOOR: cfg_q.floor_w <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage_q: merged frame waiting for the emitter
  assign in.ready = !stage_q || !busy || done;
  assign acc = in.valid && in.ready;
  assign raw = {in.data.gear_pulse, in.data.actuator_pulse,
                in.data.mode_pulse, in.data.lock_pulse};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      stage_q <= 1'b0;
    end else begin
      if (acc) pos_q <= (pos_q == PW'(FILTER_TAPS - 1)) ? '0 : pos_q + 1'b1;
      if (acc) stage_q <= 1'b1;
      else if (stage_q && (!busy || done)) stage_q <= 1'b0;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    rcmt_lane #(.TAPS(FILTER_TAPS)) u_lane (
      .clk_i, .rst_ni, .en_i(acc), .pos_i(pos_q), .raw_i(raw[c]),
      .cfg_i(cfg_q), .flags_o(flags[c])
    );
  end

  rcmt_merge #(.STEPS1(FIRST_PHASE_STEPS), .STEPS2(SECOND_PHASE_STEPS)) u_merge (
    .clk_i, .rst_ni, .en_i(acc), .flags_i(flags), .cfg_i(cfg_q), .frame_o(frame)
  );

  rcmt_emit u_emit (
    .clk_i, .rst_ni, .load_i(stage_q && (!busy || done)), .frame_i(frame),
    .busy_o(busy), .done_o(done), .out(out)
  );

`ifndef SYNTHESIS
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out.valid |-> (out.data.last == out.data.is_status))
    else $error("last without status");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q && busy && !done) |-> !in.ready)
    else $error("frame overrun");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PW'(FILTER_TAPS))
    else $error("window position out of range");
`endif

endmodule

@@ verif/rcmt_checker.sv @@
// ----------------------------------------------------------------------------
// rcmt_checker
// Watches the frame and result channels of the RC mode transition controller,
// predicts the result items of every accepted frame and compares them, in
// order and field by field, with the results the block sends.
// ----------------------------------------------------------------------------
module rcmt_checker
  import rcmt_pkg::*;
#(
  parameter int unsigned FILTER_TAPS = 5,
  parameter int unsigned FIRST_PHASE_STEPS = 100,
  parameter int unsigned SECOND_PHASE_STEPS = 90
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [WW-1:0] cfg_data_i,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  in_item_t      in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  out_item_t     out_data_i,
  output int            errors_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        cfg;
  logic [WW-1:0] win [NCH][FILTER_TAPS];
  int unsigned wpos;
  logic        lock_q, surf_q, active_q, gear_q;
  logic [1:0]  act_q;
  int unsigned ph1, ph2;
  int unsigned angle_q [6];
  int unsigned width_q [3];
  out_item_t   expected_q [$];

  function automatic out_item_t change_item(int unsigned idx, int unsigned val);
    out_item_t o;
    o = '0;
    o.output_index = idx[IW-1:0];
    o.output_value = val[WW-1:0];
    return o;
  endfunction

  function automatic int unsigned clip(int unsigned v);
    if (v < cfg.pwm_min) return cfg.pwm_min;
    if (v > cfg.pwm_max) return cfg.pwm_max;
    return v;
  endfunction

  task automatic set_angle(int unsigned idx, int unsigned val);
    if (val > 180) val = 180;
    if (angle_q[idx] != val) begin
      angle_q[idx] = val;
      expected_q.push_back(change_item(idx, val));
    end
  endtask

  task automatic set_width(int unsigned idx, int unsigned val);
    val = clip(val);
    if (width_q[idx-6] != val) begin
      width_q[idx-6] = val;
      expected_q.push_back(change_item(idx, val));
    end
  endtask

  task automatic predict_frame(in_item_t it);
    int unsigned filt [NCH];
    int unsigned raw, sum, d, a1, a2, w;
    logic [WW-1:0] pulses [NCH];
    out_item_t st;
    pulses[0] = it.lock_pulse;
    pulses[1] = it.mode_pulse;
    pulses[2] = it.actuator_pulse;
    pulses[3] = it.gear_pulse;
    for (int c = 0; c < NCH; c++) begin
      raw = pulses[c];
      if (raw > cfg.floor_w) raw = clip(raw);
      win[c][wpos] = raw[WW-1:0];
      sum = 0;
      for (int k = 0; k < FILTER_TAPS; k++) sum += win[c][k];
      filt[c] = sum / FILTER_TAPS;
    end
    wpos = (wpos + 1) % FILTER_TAPS;

    if (filt[0] < cfg.low_thr) lock_q = 1'b1;
    else if (filt[0] > cfg.high_thr) lock_q = 1'b0;
    if (!lock_q && !active_q) begin
      if (filt[1] < cfg.low_thr && surf_q) begin
        surf_q = 1'b0;
        active_q = 1'b1;
      end else if (filt[1] > cfg.high_thr && !surf_q) begin
        surf_q = 1'b1;
        active_q = 1'b1;
      end
    end
    if (filt[2] > cfg.high_thr) act_q = ACT_EXTEND;
    else if (filt[2] < cfg.low_thr && filt[2] > cfg.floor_w) act_q = ACT_RETRACT;
    else act_q = ACT_STOP;
    if (filt[3] > cfg.high_thr) gear_q = 1'b1;
    else if (filt[3] < cfg.low_thr && filt[3] > cfg.floor_w) gear_q = 1'b0;

    if (active_q) begin
      if (ph1 < FIRST_PHASE_STEPS) begin
        d = (ph1 * 110) / FIRST_PHASE_STEPS;
        if (!surf_q) begin
          set_angle(0, 20 + d);
          set_angle(1, 155 - d);
        end else begin
          set_angle(0, 130 - d);
          set_angle(1, 45 + d);
        end
        ph1++;
      end else if (ph2 < SECOND_PHASE_STEPS) begin
        d = (ph2 * 90) / SECOND_PHASE_STEPS;
        if (!surf_q) begin
          a1 = d;
          a2 = 170 - d;
        end else begin
          a1 = 90 - d;
          a2 = 80 + d;
        end
        set_angle(2, a1);
        set_angle(3, a1);
        set_angle(4, a2);
        set_angle(5, a2);
        ph2++;
      end else begin
        active_q = 1'b0;
        ph1 = 0;
        ph2 = 0;
      end
    end

    if (act_q == ACT_EXTEND) w = cfg.pwm_max;
    else if (act_q == ACT_RETRACT) w = cfg.pwm_min;
    else w = (int'(cfg.pwm_min) + int'(cfg.pwm_max)) / 2;
    set_width(6, w);
    set_width(7, w);
    set_width(8, gear_q ? cfg.pwm_max : cfg.pwm_min);

    st = '0;
    st.is_status = 1'b1;
    st.locked = lock_q;
    st.surface_mode = surf_q;
    st.transition_active = active_q;
    st.actuator_state = act_q;
    st.gear_down = gear_q;
    st.last = 1'b1;
    expected_q.push_back(st);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      cfg = '{pwm_min: 1000, pwm_max: 2000, low_thr: 1100, high_thr: 1900, floor_w: 500};
      for (int c = 0; c < NCH; c++)
        for (int k = 0; k < FILTER_TAPS; k++) win[c][k] = '0;
      wpos = 0;
      lock_q = 1'b1;
      surf_q = 1'b0;
      active_q = 1'b0;
      gear_q = 1'b0;
      act_q = ACT_STOP;
      ph1 = 0;
      ph2 = 0;
      angle_q = '{130, 45, 90, 90, 80, 80};
      width_q = '{1500, 1500, 1000};
      expected_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PWM_MIN:  cfg.pwm_min = cfg_data_i;
          CFG_PWM_MAX:  cfg.pwm_max = cfg_data_i;
          CFG_LOW_THR:  cfg.low_thr = cfg_data_i;
          CFG_HIGH_THR: cfg.high_thr = cfg_data_i;
          CFG_FLOOR:    cfg.floor_w = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_i);
          errors_o++;
        end else begin
          exp_item = expected_q.pop_front();
          if (exp_item !== out_data_i) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_item, out_data_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_frame(in_data_i);
    end
    pending_o = expected_q.size();
  end
endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives frames and register writes into the RC mode transition controller
// with random idling and back-pressure; the checker predicts and compares
// every result item and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rcmt_pkg::*;

  localparam int unsigned WATCHDOG = 20000;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [2:0]    cfg_idx_i;
  logic [WW-1:0] cfg_data_i;
  int            errors;
  int            pending;
  int            sent;
  int            idle_cycles;
  bit            src_gaps;
  bit            snk_gaps;
  bit            hold_sink;

  rcmt_if #(.T(in_item_t))  frame_ch ();
  rcmt_if #(.T(out_item_t)) result_ch ();

  rc_mode_transition_controller i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in         (frame_ch.sink),
    .out        (result_ch.source)
  );

  rcmt_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (frame_ch.valid),
    .in_ready_i  (frame_ch.ready),
    .in_data_i   (frame_ch.data),
    .out_valid_i (result_ch.valid),
    .out_ready_i (result_ch.ready),
    .out_data_i  (result_ch.data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    frame_ch.valid = 1'b0;
    frame_ch.data = '0;
    result_ch.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PWM_MIN;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sink: random stall bursts, or a long hold when asked
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        result_ch.ready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_sink = 1'b0;
      end else if (snk_gaps && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        result_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (frame_ch.valid && frame_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[WW-1:0];
    @(posedge clk_i);
  endtask

  task automatic drain;
    frame_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_regs(int unsigned lo, int unsigned hi, int unsigned lt,
                          int unsigned ht, int unsigned fl);
    drain();
    write_reg(CFG_PWM_MIN, lo);
    write_reg(CFG_PWM_MAX, hi);
    write_reg(CFG_LOW_THR, lt);
    write_reg(CFG_HIGH_THR, ht);
    write_reg(CFG_FLOOR, fl);
    cfg_we_i <= 1'b0;
  endtask

  // valid stays up after a transfer; drain() drops it, the next call only for a random gap
  task automatic send_frame(int unsigned lk, int unsigned md, int unsigned ac,
                            int unsigned gr);
    int n;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 7);
      frame_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.data <= '{lock_pulse: lk[WW-1:0], mode_pulse: md[WW-1:0],
                       actuator_pulse: ac[WW-1:0], gear_pulse: gr[WW-1:0]};
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  function automatic int unsigned any_width();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32767;
      2: return $urandom_range(0, 32767);
      default: return $urandom_range(800, 2200);
    endcase
  endfunction

  function automatic int unsigned switch_width();
    case ($urandom_range(0, 2))
      0: return $urandom_range(900, 1050);
      1: return $urandom_range(1950, 2100);
      default: return $urandom_range(1200, 1800);
    endcase
  endfunction

  initial begin
    int unsigned md;
    sent = 0;
    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    hold_sink = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed: extremes, min above max
    send_frame(0, 0, 0, 0);
    send_frame(32767, 32767, 32767, 32767);
    send_frame(500, 501, 25000, 1);
    send_frame(21845, 10922, 5461, 27306);
    set_regs(2000, 1000, 1100, 1900, 500);
    repeat (3) send_frame(1500, 2500, 700, 1200);
    set_regs(0, 25000, 0, 25000, 0);
    repeat (3) send_frame(25000, 0, 25000, 0);
    set_regs(32767, 32767, 32767, 32767, 32767);
    repeat (2) send_frame(32767, 0, 32767, 0);
    set_regs(1000, 2000, 1100, 1900, 500);
    // unlock, request surface, mode flips and relock mid-transition ignored
    repeat (6) send_frame(2000, 2000, 2000, 2000);
    repeat (5) send_frame(1000, 1000, 1000, 1000);

    src_gaps = 1'b1;
    snk_gaps = 1'b1;
    // back-pressure: sink holds while frames keep coming
    hold_sink = 1'b1;
    repeat (15) send_frame(2000, 2000, 2000, 2000);
    drain();

    // transition runs to its end with random content, then flight requested
    md = 1000;
    repeat (205) send_frame($urandom_range(1950, 2100), md + $urandom_range(0, 50),
                            switch_width(), switch_width());
    set_regs(1200, 1800, 1300, 1700, 900);
    repeat (60) send_frame(switch_width(), switch_width(), any_width(), any_width());
    set_regs($urandom_range(0, 25000), $urandom_range(0, 25000),
             $urandom_range(0, 25000), $urandom_range(0, 25000), $urandom_range(0, 25000));
    repeat (40) send_frame(any_width(), any_width(), any_width(), any_width());
    set_regs(1000, 2000, 1100, 1900, 500);

    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    repeat (30) send_frame(any_width(), switch_width(), any_width(), switch_width());
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
